// ----- src/fnbg_pkg.sv -----
// Shared types and constants for the filtered noise burst generator.
package fnbg_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HOLD    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COEF    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GAIN    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SEED    = 3'd5;

  localparam logic [15:0] ATTACK_RST  = 16'd576;
  localparam logic [15:0] HOLD_RST    = 16'd960;
  localparam logic [15:0] RELEASE_RST = 16'd7104;
  localparam logic [15:0] COEF_RST    = 16'd7864;
  localparam logic [15:0] GAIN_RST    = 16'd19661;
  localparam logic [31:0] SEED_RST    = 32'hDEAD_BEEF;

  // LCG multiplier 0x0019_660D split into halves
  localparam logic [15:0] LCG_MUL_LO = 16'h660D;
  localparam logic [15:0] LCG_MUL_HI = 16'h0019;
  localparam logic [31:0] LCG_ADD    = 32'h3C6E_F35F;

  localparam logic [16:0] ENV_ONE   = 17'd32768;
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV,
    S_DIV,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_FILT,
    S_FILT2,
    S_ENVM,
    S_GAIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic               en;
    logic signed [16:0] a;
    logic signed [16:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

endpackage

// ----- src/fnbg_mul.sv -----
// Shared 17x17 signed multiplier with registered product.
module fnbg_mul (
  input  logic                      clk,
  input  fnbg_pkg::mul_req_t        req,
  output logic signed [33:0]        prod_r
);
  import fnbg_pkg::*;

  logic signed [33:0] prod_nxt;

  assign prod_nxt = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- src/fnbg_div.sv -----
// Restoring divider giving floor(dividend * 2^15 / divisor) for dividend < divisor.
module fnbg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fnbg_pkg::div_req_t         req,
  output logic                       done_r,
  output logic [fnbg_pkg::DIV_STEPS-1:0] quot_r
);
  import fnbg_pkg::*;

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [15:0]       rem_r;
  logic [15:0]       div_r;
  logic [16:0]       rem2;
  logic              ge;
  logic [16:0]       diff;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, div_r};
  assign diff = rem2 - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so the doubled value fits 17 bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[15:0] : rem2[15:0];
      quot_r <= {quot_r[DIV_STEPS-2:0], ge};
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule

// ----- src/filtered_noise_burst_generator.sv -----
// Top level: sequencer and datapath of the filtered noise burst generator.
// Sequence per word: envelope decode, the 15-step divider in attack or release only,
//   the LCG states M0 to M3, filter, envelope and gain products, then the output register.
// One word at a time: in_stall is high while a word is in work, and S_OUT waits on out_stall.
// One shared 17x17 multiplier takes all six products of every word.
// Sync active-low reset: register defaults, noise seed; filter, counter, out_valid cleared.
module filtered_noise_burst_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_sample,
  output logic                          out_done_res,
  input  logic                          cfg_we,
  input  logic [fnbg_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [fnbg_pkg::CFG_DW-1:0]   cfg_wdata
);
  import fnbg_pkg::*;

  state_t state_r, state_nxt;

  logic [15:0] attack_r, hold_r, release_r, coef_r, gain_r;
  logic [31:0] seed_r;

  logic [31:0]        noise_r;
  logic signed [15:0] lp_r;
  logic [17:0]        cnt_r;
  logic [16:0]        env_r;
  logic               done_r;
  logic               rel_phase_r;
  logic [31:0]        acc_r;

  logic               out_valid_r;
  logic signed [15:0] out_sample_r;
  logic               out_done_r;

  mul_req_t           mul_req;
  logic signed [33:0] prod_r;
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_STEPS-1:0] quot;

  logic        accept;
  logic        out_free;
  logic [17:0] total;
  logic [16:0] ah;
  logic [17:0] rel;
  logic        in_attack, in_hold, in_rel, use_div;
  logic signed [15:0] noise;
  logic signed [16:0] diff;
  logic signed [17:0] lp_sum;
  logic signed [15:0] y;

  fnbg_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  fnbg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .done_r (div_done),
    .quot_r (quot)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // envelope segment decode
  assign total     = {2'b0, attack_r} + {2'b0, hold_r} + {2'b0, release_r};
  assign ah        = {1'b0, attack_r} + {1'b0, hold_r};
  assign rel       = cnt_r - {1'b0, ah};
  assign in_attack = cnt_r < {2'b0, attack_r};
  assign in_hold   = cnt_r < {1'b0, ah};
  assign in_rel    = rel < {2'b0, release_r};
  assign use_div   = in_attack || (!in_hold && in_rel);

  // noise is the top half of the LCG state, offset to signed
  assign noise  = {~noise_r[31], noise_r[30:16]};
  assign diff   = {noise[15], noise} - {lp_r[15], lp_r};
  assign lp_sum = {{2{lp_r[15]}}, lp_r} + prod_r[33:16];
  assign y      = prod_r[30:15];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_ENV;
      S_ENV:   state_nxt = use_div ? S_DIV : S_M0;
      S_DIV:   if (div_done) state_nxt = S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_FILT;
      S_FILT:  state_nxt = S_FILT2;
      S_FILT2: state_nxt = S_ENVM;
      S_ENVM:  state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider launch and in_stall
  always_comb begin
    mul_req          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = in_attack ? cnt_r[15:0] : rel[15:0];
    div_req.divisor  = in_attack ? attack_r : release_r;
    in_stall         = 1'b1;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_ENV:  div_req.start = use_div;
      S_M0: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, noise_r[15:0]};
        mul_req.b  = {1'b0, LCG_MUL_LO};
      end
      S_M1: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, noise_r[31:16]};
        mul_req.b  = {1'b0, LCG_MUL_LO};
      end
      S_M2: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, noise_r[15:0]};
        mul_req.b  = {1'b0, LCG_MUL_HI};
      end
      S_FILT: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, coef_r};
        mul_req.b  = diff;
      end
      S_ENVM: begin
        mul_req.en = 1'b1;
        mul_req.a  = {lp_r[15], lp_r};
        mul_req.b  = env_r;
      end
      S_GAIN: begin
        mul_req.en = 1'b1;
        mul_req.a  = {y[15], y};
        mul_req.b  = {1'b0, gain_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      hold_r    <= HOLD_RST;
      release_r <= RELEASE_RST;
      coef_r    <= COEF_RST;
      gain_r    <= GAIN_RST;
      seed_r    <= SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_r  <= cfg_wdata[15:0];
        REG_HOLD:    hold_r    <= cfg_wdata[15:0];
        REG_RELEASE: release_r <= cfg_wdata[15:0];
        REG_COEF:    coef_r    <= cfg_wdata[15:0];
        REG_GAIN:    gain_r    <= cfg_wdata[15:0];
        REG_SEED:    seed_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= SEED_RST;
      lp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      if (accept && in_restart) begin
        noise_r <= seed_r;
        lp_r    <= '0;
        cnt_r   <= '0;
      end
      if (state_r == S_ENV && cnt_r < total) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_M3) begin
        noise_r <= acc_r + {prod_r[15:0], 16'h0000};
      end
      if (state_r == S_FILT2) begin
        lp_r <= lp_sum[15:0];
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_ENV: begin
        done_r      <= cnt_r >= total;
        rel_phase_r <= !in_attack;
        if (in_attack) begin
          env_r <= '0;
        end else if (in_hold) begin
          env_r <= ENV_ONE;
        end else begin
          env_r <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          env_r <= rel_phase_r ? ENV_ONE - {2'b0, quot} : {2'b0, quot};
        end
      end
      S_M1: acc_r <= prod_r[31:0] + LCG_ADD;
      S_M2: acc_r <= acc_r + {prod_r[15:0], 16'h0000};
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_sample_r <= prod_r[31:16];
      out_done_r   <= done_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_done_res = out_done_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ENV))
    else $error("accepted word did not start the sequence");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + 18'd1 || cnt_r == '0))
    else $error("sample counter moved by other than one step or clear");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M0 && done_r) |-> (env_r == '0))
    else $error("envelope not zero at end of burst");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the filtered noise burst generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fnbg_pkg::*;

  localparam logic [CFG_AW-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE7 = 3'd7;
  localparam logic [31:0] LCG_MULT = 32'd1664525;
  localparam logic [31:0] LCG_INC  = 32'd1013904223;
  localparam int WORDS_TOTAL = 1325;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SQUEEZE_CYCLES = 400;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               done;
  } burst_word_t;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_AW-1:0] idx;
    logic [CFG_DW-1:0] data;
    logic              rs;
    logic              pinned;
    burst_word_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_restart;
  logic out_valid, out_stall;
  logic signed [15:0] out_sample;
  logic out_done_res;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  filtered_noise_burst_generator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .out_done_res (out_done_res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror and generator state
  logic [15:0] atk_len, hold_len, rel_len, lp_coef, gain;
  logic [31:0] seed, lcg_state;
  logic signed [15:0] lp_level;
  logic [17:0] sample_cnt;

  burst_word_t burst_q [$];
  int mismatches = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int squeeze_req = 0;
  bit calm = 1'b0;

  row_t dir_rows [0:42] = '{
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b1, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_GAIN,    32'hFFFF,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_COEF,    32'hFFFF,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    // shortest envelope: one sample of attack, one of release
    '{ROW_WRITE, REG_ATTACK,  32'd1,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_HOLD,    32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_RELEASE, 32'd1,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b1, '{16'sd0, 1'b1}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b1, '{16'sd0, 1'b1}},
    // no attack, no release: hold only
    '{ROW_WRITE, REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_RELEASE, 32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_HOLD,    32'd2,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b1, '{16'sd0, 1'b1}},
    // total drops under the counter, then rises past it again
    '{ROW_WRITE, REG_HOLD,    32'd1,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b1, '{16'sd0, 1'b1}},
    '{ROW_WRITE, REG_HOLD,    32'd3,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_COEF,    32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_COEF,    32'hFFFF,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_GAIN,    32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b1, '{16'sd0, 1'b0}},
    // new seed is only picked up on restart
    '{ROW_WRITE, REG_GAIN,    32'hFFFF,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_SEED,    32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_SEED,    32'hFFFFFFFF, 1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_SPARE6,  32'hFFFFFFFF, 1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_SPARE7,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_ATTACK,  32'hFFFF,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_HOLD,    32'hFFFF,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WRITE, REG_RELEASE, 32'hFFFF,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{ROW_WORD,  REG_ATTACK,  32'd0,        1'b0, 1'b0, '{16'sd0, 1'b0}}
  };

  function automatic logic [16:0] envelope_at(logic [17:0] t);
    logic [17:0] rel;
    if (t < 18'(atk_len))
      return 17'((longint'(t) * 32768) / atk_len);
    if (t < 18'(atk_len) + 18'(hold_len))
      return ENV_ONE;
    rel = t - 18'(atk_len) - 18'(hold_len);
    if (rel < 18'(rel_len))
      return ENV_ONE - 17'((longint'(rel) * 32768) / rel_len);
    return 17'd0;
  endfunction

  function automatic burst_word_t next_burst_sample(logic rs);
    logic [17:0] total, t;
    logic [16:0] env;
    longint noise, y;
    burst_word_t res;
    if (rs) begin
      lcg_state = seed;
      lp_level = '0;
      sample_cnt = '0;
    end
    total = 18'(atk_len) + 18'(hold_len) + 18'(rel_len);
    t = sample_cnt;
    env = envelope_at(t);
    lcg_state = lcg_state * LCG_MULT + LCG_INC;
    noise = longint'(lcg_state[31:16]) - 32768;
    // >>> on a signed product is a floor shift
    lp_level = 16'(longint'(lp_level) +
                   ((longint'(lp_coef) * (noise - longint'(lp_level))) >>> 16));
    y = (longint'(lp_level) * longint'(env)) >>> 15;
    y = (y * longint'(gain)) >>> 16;
    if (t < total)
      sample_cnt = t + 18'd1;
    res.sample = 16'(y);
    res.done = (t >= total);
    return res;
  endfunction

  // register writes only once every outstanding word has come back
  task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    if (!cfg_we) begin
      in_valid <= 1'b0;
      while (burst_q.size() != 0) @(posedge clk);
    end
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ATTACK:  atk_len = val[15:0];
      REG_HOLD:    hold_len = val[15:0];
      REG_RELEASE: rel_len = val[15:0];
      REG_COEF:    lp_coef = val[15:0];
      REG_GAIN:    gain = val[15:0];
      REG_SEED:    seed = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(input logic rs, input logic pinned, input burst_word_t want);
    burst_word_t predicted;
    if (cfg_we) cfg_we <= 1'b0;
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_burst_sample(rs);
    burst_q.push_back(pinned ? want : predicted);
    words_sent++;
  endtask

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [15:0] pick_q16();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    atk_len = ATTACK_RST;
    hold_len = HOLD_RST;
    rel_len = RELEASE_RST;
    lp_coef = COEF_RST;
    gain = GAIN_RST;
    seed = SEED_RST;
    lcg_state = SEED_RST;
    lp_level = '0;
    sample_cnt = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE)
        set_reg(dir_rows[i].idx, dir_rows[i].data);
      else
        send_word(dir_rows[i].rs, dir_rows[i].pinned, dir_rows[i].want);
    end

    phase = 0;
    while (words_sent < WORDS_TOTAL) begin
      calm = (phase >= 8 && phase < 13);
      if (phase == 0 || $urandom_range(0, 1)) set_reg(REG_ATTACK, pick_len());
      if (phase == 0 || $urandom_range(0, 1)) set_reg(REG_HOLD, pick_len());
      if (phase == 0 || $urandom_range(0, 1)) set_reg(REG_RELEASE, pick_len());
      if ($urandom_range(0, 2) == 0) set_reg(REG_COEF, pick_q16());
      if ($urandom_range(0, 2) == 0) set_reg(REG_GAIN, pick_q16());
      if ($urandom_range(0, 2) == 0) set_reg(REG_SEED, pick_seed());
      if ($urandom_range(0, 7) == 0)
        set_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, $urandom);
      // back-pressure the output long enough for the input to stall
      if (phase == 3 || phase == 17) squeeze_req++;
      n = $urandom_range(20, 70);
      for (int k = 0; k < n; k++)
        send_word((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 31) == 0,
                  1'b0, '0);
      phase++;
    end

    in_valid <= 1'b0;
    while (burst_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // receiver: random stalls plus the occasional long hold-off
  initial begin
    int hold_left;
    int squeeze_seen;
    hold_left = 0;
    squeeze_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_seen != squeeze_req) begin
        squeeze_seen = squeeze_req;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 16);
      end
    end
  end

  always @(posedge clk) begin
    burst_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (burst_q.size() == 0) begin
        mismatches++;
        if (mismatches < 40)
          $display("%0t: unexpected word, got sample %0d done %0b",
                   $time, out_sample, out_done_res);
      end else begin
        want = burst_q.pop_front();
        if (out_sample !== want.sample) begin
          mismatches++;
          if (mismatches < 40)
            $display("%0t: sample expected %0d, got %0d", $time, want.sample, out_sample);
        end
        if (out_done_res !== want.done) begin
          mismatches++;
          if (mismatches < 40)
            $display("%0t: done expected %0b, got %0b", $time, want.done, out_done_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
